// ----- src/tms_pkg.sv -----
// Package for the triangle midpoint subdivider: vertex item types, state
// enums, derived widths and shared helper functions. No dependencies.
package tms_pkg;

    localparam int POS_BITS  = 16;
    localparam int UNIT_BITS = 16;
    localparam int TEX_BITS  = 16;

    localparam int SUM_W   = UNIT_BITS + 1;
    localparam int L2_W    = 2 * SUM_W;
    localparam int ROOT_FB = 8;
    localparam int X_W     = L2_W + 2 * ROOT_FB;
    localparam int ROOT_W  = X_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int FRAC_B  = UNIT_BITS - 2;
    localparam int Q_W     = UNIT_BITS;
    localparam int N_W     = SUM_W + FRAC_B + ROOT_FB + 1;
    localparam int DREM_W  = ROOT_W + 1;
    localparam int CNT_W   = 5;

    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_B;

    typedef struct packed {
        logic signed [UNIT_BITS-1:0] x;
        logic signed [UNIT_BITS-1:0] y;
        logic signed [UNIT_BITS-1:0] z;
    } nrm3_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0]  pos_x;
        logic signed [POS_BITS-1:0]  pos_y;
        logic signed [POS_BITS-1:0]  pos_z;
        logic signed [UNIT_BITS-1:0] nrm_x;
        logic signed [UNIT_BITS-1:0] nrm_y;
        logic signed [UNIT_BITS-1:0] nrm_z;
        logic signed [UNIT_BITS-1:0] tan_x;
        logic signed [UNIT_BITS-1:0] tan_y;
        logic signed [UNIT_BITS-1:0] tan_z;
        logic [TEX_BITS-1:0]         tex_u;
        logic [TEX_BITS-1:0]         tex_v;
    } vtx_in_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0]  out_pos_x;
        logic signed [POS_BITS-1:0]  out_pos_y;
        logic signed [POS_BITS-1:0]  out_pos_z;
        logic signed [UNIT_BITS-1:0] out_nrm_x;
        logic signed [UNIT_BITS-1:0] out_nrm_y;
        logic signed [UNIT_BITS-1:0] out_nrm_z;
        logic signed [UNIT_BITS-1:0] out_tan_x;
        logic signed [UNIT_BITS-1:0] out_tan_y;
        logic signed [UNIT_BITS-1:0] out_tan_z;
        logic [TEX_BITS-1:0]         out_tex_u;
        logic [TEX_BITS-1:0]         out_tex_v;
        logic                        run_last;
    } vtx_out_t;

    typedef enum logic [2:0] {
        N_IDLE, N_SQ, N_CHK, N_ROOT, N_DLOAD, N_DIV, N_DSTORE, N_DONE
    } norm_state_t;

    typedef enum logic [1:0] {
        S_COLLECT, S_LOAD, S_WAIT, S_OUT
    } top_state_t;

    function automatic logic signed [POS_BITS-1:0] avg_s(
        input logic signed [POS_BITS-1:0] a,
        input logic signed [POS_BITS-1:0] b
    );
        logic signed [POS_BITS:0] s;
        begin
            s = {a[POS_BITS-1], a} + {b[POS_BITS-1], b};
            return s[POS_BITS:1];
        end
    endfunction

    function automatic logic [TEX_BITS-1:0] avg_u(
        input logic [TEX_BITS-1:0] a,
        input logic [TEX_BITS-1:0] b
    );
        logic [TEX_BITS:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[TEX_BITS:1];
        end
    endfunction

    function automatic vtx_out_t pass_vtx(input vtx_in_t v);
        vtx_out_t o;
        begin
            o.out_pos_x = v.pos_x;
            o.out_pos_y = v.pos_y;
            o.out_pos_z = v.pos_z;
            o.out_nrm_x = v.nrm_x;
            o.out_nrm_y = v.nrm_y;
            o.out_nrm_z = v.nrm_z;
            o.out_tan_x = v.tan_x;
            o.out_tan_y = v.tan_y;
            o.out_tan_z = v.tan_z;
            o.out_tex_u = v.tex_u;
            o.out_tex_v = v.tex_v;
            o.run_last  = 1'b0;
            return o;
        end
    endfunction

endpackage

// ----- src/triangle_midpoint_subdivider.sv -----
// Triangle midpoint subdivider top level: corner capture, emit sequencer and
// output register. Uses tms_pkg and tms_norm.
// The third corner starts six results: each corner result is registered in S_LOAD
// and shown in S_OUT, each midpoint waits in S_WAIT for the bit-serial square,
// root and divide in tms_norm (root and divide are skipped when the normal sum
// is zero). No corner is taken until the sixth result is handed off.
// Reset clears the corner count and sequencer; held data is kept.
module triangle_midpoint_subdivider
    import tms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  vtx_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output vtx_out_t out_data
);

    top_state_t state_reg, state_next;
    logic [1:0] count_reg;
    logic [2:0] slot_reg;
    vtx_in_t    c0_reg, c1_reg, c2_reg;
    vtx_out_t   out_reg;
    logic       norm_start, norm_done;
    nrm3_t      nrm_a, nrm_b, nrm_res;
    vtx_in_t    ea, eb, corner;
    vtx_out_t   mid;

    always_comb
    begin
        unique case (slot_reg)
            3'd3:    begin ea = c0_reg; eb = c1_reg; end
            3'd4:    begin ea = c1_reg; eb = c2_reg; end
            default: begin ea = c0_reg; eb = c2_reg; end
        endcase
        unique case (slot_reg)
            3'd0:    corner = c0_reg;
            3'd1:    corner = c1_reg;
            default: corner = c2_reg;
        endcase
        nrm_a = '{x: ea.nrm_x, y: ea.nrm_y, z: ea.nrm_z};
        nrm_b = '{x: eb.nrm_x, y: eb.nrm_y, z: eb.nrm_z};
        mid.out_pos_x = avg_s(ea.pos_x, eb.pos_x);
        mid.out_pos_y = avg_s(ea.pos_y, eb.pos_y);
        mid.out_pos_z = avg_s(ea.pos_z, eb.pos_z);
        mid.out_nrm_x = nrm_res.x;
        mid.out_nrm_y = nrm_res.y;
        mid.out_nrm_z = nrm_res.z;
        mid.out_tan_x = '0;
        mid.out_tan_y = '0;
        mid.out_tan_z = '0;
        mid.out_tex_u = avg_u(ea.tex_u, eb.tex_u);
        mid.out_tex_v = avg_u(ea.tex_v, eb.tex_v);
        mid.run_last  = (slot_reg == 3'd5);
    end

    tms_norm u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .nrm_a  (nrm_a),
        .nrm_b  (nrm_b),
        .done   (norm_done),
        .result (nrm_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_COLLECT: if (in_valid && count_reg == 2'd2) state_next = S_LOAD;
            S_LOAD:    state_next = (slot_reg < 3'd3) ? S_OUT : S_WAIT;
            S_WAIT:    if (norm_done) state_next = S_OUT;
            S_OUT:     if (out_ready) state_next = (slot_reg == 3'd5) ? S_COLLECT : S_LOAD;
            default:   state_next = S_COLLECT;
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == S_COLLECT);
        out_valid  = (state_reg == S_OUT);
        norm_start = (state_reg == S_LOAD) && (slot_reg >= 3'd3);
    end

    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            count_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_valid && in_ready)
            begin
                count_reg <= (count_reg == 2'd2) ? 2'd0 : count_reg + 2'd1;
                slot_reg  <= '0;
            end
            if (out_valid && out_ready && slot_reg != 3'd5)
            begin
                slot_reg <= slot_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            case (count_reg)
                2'd0:    c0_reg <= in_data;
                2'd1:    c1_reg <= in_data;
                default: c2_reg <= in_data;
            endcase
        end
        if (state_reg == S_LOAD && slot_reg < 3'd3)
        begin
            out_reg <= pass_vtx(corner);
        end
        if (state_reg == S_WAIT && norm_done)
        begin
            out_reg <= mid;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while an item is pending");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("corner count out of range");

    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.run_last) |-> (slot_reg == 3'd5))
        else $error("run_last on wrong slot");

    a_wait_done: assert property (@(posedge clk) disable iff (!rst_n)
        norm_start |=> (state_reg == S_WAIT))
        else $error("normal unit started outside the midpoint path");

endmodule

// ----- src/tms_norm.sv -----
// Bit-serial normal unit: sums two normals, squares by shift-add, takes the
// root two bits a step and divides one quotient bit a step. Uses tms_pkg.
module tms_norm
    import tms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  nrm3_t nrm_a,
    input  nrm3_t nrm_b,
    output logic  done,
    output nrm3_t result
);

    norm_state_t state_reg, state_next;
    logic [1:0]       cidx_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] mag_reg [3];
    logic [2:0]       neg_reg;
    logic [L2_W-1:0]  l2_reg, mcand_reg;
    logic [SUM_W-1:0] mplier_reg;
    logic [X_W-1:0]   xs_reg;
    logic [REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [DREM_W-1:0] drem_reg;
    logic [Q_W-1:0]   nlo_reg, q_reg;
    logic signed [UNIT_BITS-1:0] res_reg [3];

    logic signed [SUM_W-1:0] s_in [3];
    logic [SUM_W-1:0]  mag_in [3];
    logic [REM_W-1:0]  rem_sh, trial;
    logic [N_W-1:0]    numer;
    logic [DREM_W-1:0] drem_sh;
    logic [Q_W-1:0]    q_sat;

    always_comb
    begin
        s_in[0] = SUM_W'(nrm_a.x) + SUM_W'(nrm_b.x);
        s_in[1] = SUM_W'(nrm_a.y) + SUM_W'(nrm_b.y);
        s_in[2] = SUM_W'(nrm_a.z) + SUM_W'(nrm_b.z);
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i] = s_in[i][SUM_W-1] ? SUM_W'(-s_in[i]) : SUM_W'(s_in[i]);
        end
        rem_sh  = {rem_reg[REM_W-3:0], xs_reg[X_W-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        numer   = (N_W'(mag_reg[cidx_reg]) << (FRAC_B + ROOT_FB))
                  + N_W'(root_reg >> 1);
        drem_sh = {drem_reg[DREM_W-2:0], nlo_reg[Q_W-1]};
        q_sat   = (q_reg > ONE_Q) ? ONE_Q : q_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:   if (start) state_next = N_SQ;
            N_SQ:     if (cnt_reg == CNT_W'(SUM_W - 1) && cidx_reg == 2'd2)
                          state_next = N_CHK;
            N_CHK:    state_next = (l2_reg == '0) ? N_DONE : N_ROOT;
            N_ROOT:   if (cnt_reg == CNT_W'(ROOT_W - 1)) state_next = N_DLOAD;
            N_DLOAD:  state_next = N_DIV;
            N_DIV:    if (cnt_reg == CNT_W'(Q_W - 1)) state_next = N_DSTORE;
            N_DSTORE: state_next = (cidx_reg == 2'd2) ? N_DONE : N_DLOAD;
            N_DONE:   state_next = N_IDLE;
            default:  state_next = N_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == N_DONE);
    end

    assign result.x = res_reg[0];
    assign result.y = res_reg[1];
    assign result.z = res_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cidx_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                N_IDLE:
                begin
                    cidx_reg <= '0;
                    cnt_reg  <= '0;
                end
                N_SQ:
                begin
                    if (cnt_reg == CNT_W'(SUM_W - 1))
                    begin
                        cnt_reg <= '0;
                        if (cidx_reg != 2'd2) cidx_reg <= cidx_reg + 2'd1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                N_CHK:    cnt_reg <= '0;
                N_ROOT:
                begin
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    cidx_reg <= '0;
                end
                N_DLOAD:  cnt_reg <= '0;
                N_DIV:    cnt_reg <= cnt_reg + CNT_W'(1);
                N_DSTORE: cidx_reg <= cidx_reg + 2'd1;
                N_DONE:   cnt_reg <= '0;
                default:  cnt_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_in[i];
                        neg_reg[i] <= s_in[i][SUM_W-1];
                    end
                    l2_reg     <= '0;
                    mcand_reg  <= L2_W'(mag_in[0]);
                    mplier_reg <= mag_in[0];
                end
            end
            N_SQ:
            begin
                if (mplier_reg[0]) l2_reg <= l2_reg + mcand_reg;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    mcand_reg  <= L2_W'(mag_reg[cidx_reg + 2'd1]);
                    mplier_reg <= mag_reg[cidx_reg + 2'd1];
                end
                else
                begin
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            N_CHK:
            begin
                xs_reg   <= {l2_reg, {(2 * ROOT_FB){1'b0}}};
                rem_reg  <= '0;
                root_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    res_reg[i] <= '0;
                end
            end
            N_ROOT:
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                xs_reg <= xs_reg << 2;
            end
            N_DLOAD:
            begin
                drem_reg <= DREM_W'(numer >> Q_W);
                nlo_reg  <= numer[Q_W-1:0];
                q_reg    <= '0;
            end
            N_DIV:
            begin
                if (drem_sh >= {1'b0, root_reg})
                begin
                    drem_reg <= drem_sh - {1'b0, root_reg};
                    q_reg    <= {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_sh;
                    q_reg    <= {q_reg[Q_W-2:0], 1'b0};
                end
                nlo_reg <= nlo_reg << 1;
            end
            N_DSTORE:
            begin
                res_reg[cidx_reg] <= neg_reg[cidx_reg] ? -$signed(q_sat) : $signed(q_sat);
            end
            default:
            begin
            end
        endcase
    end

endmodule
